// ===== sv/afpg_pkg.sv =====
`timescale 1ns / 1ps

package afpg_pkg;

    // width of the wrapping microsecond time base
    localparam int TIME_BITS = 48;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;

    // command codes
    typedef enum logic [1:0] {
        CMD_UPDATE  = 2'd0,
        CMD_GRANT   = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_t;

    // register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PACING_MODE  = 3'd0,
        REG_WAIT_NORMAL  = 3'd1,
        REG_WAIT_FAST    = 3'd2,
        REG_MIN_SPACING  = 3'd3,
        REG_CATCH_UP     = 3'd4,
        REG_BUDGET_CAP   = 3'd5,
        REG_FRAME_SAMPLE = 3'd6
    } cfg_idx_t;

    // register reset values
    localparam logic        RST_PACING_MODE   = 1'b0;
    localparam logic [15:0] RST_WAIT_NORMAL   = 16'd3000;
    localparam logic [15:0] RST_WAIT_FAST     = 16'd2900;
    localparam logic [15:0] RST_MIN_SPACING   = 16'd1700;
    localparam logic [19:0] RST_CATCH_UP      = 20'd72000;
    localparam logic [15:0] RST_BUDGET_CAP    = 16'd12000;
    localparam logic [11:0] RST_FRAME_SAMPLES = 12'd144;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] now_us;
        logic        need_more_blocks;
        logic        initialized;
        logic [31:0] processed_frames;
        logic [15:0] grant_samples;
    } in_item_t;

    typedef struct packed {
        logic        gate_passed;
        logic        frame_queued;
        logic [31:0] queued_count;
        logic [15:0] budget_level;
    } out_item_t;

    typedef struct packed {
        logic        pacing_mode;
        logic [15:0] wait_normal_us;
        logic [15:0] wait_fast_us;
        logic [15:0] min_spacing_us;
        logic [19:0] catch_up_limit_us;
        logic [15:0] budget_cap;
        logic [11:0] frame_samples;
    } cfg_t;

endpackage

// ===== sv/afpg_core.sv =====
`timescale 1ns / 1ps

module afpg_core import afpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    localparam int TPAD = TIME_BITS - 16;

    logic [TIME_BITS-1:0] mark_reg, mark_next;
    logic [TIME_BITS-1:0] open_reg, open_next;
    logic [TIME_BITS-1:0] paced_reg, paced_next;
    logic                 seeded_reg, seeded_next;
    logic [31:0]          queued_reg, queued_next;
    logic [15:0]          budget_reg, budget_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] wait_normal_t, wait_sel_t, spacing_t, limit_t;
    logic [TIME_BITS-1:0] mark_eff, open_eff, paced_eff;
    logic [TIME_BITS-1:0] lag, since_open, since_paced;
    logic [16:0]          budget_sum;
    logic [15:0]          frame_16;
    logic                 passed, queued, count_match;

    // widen fields to the time base
    assign now_t         = item.now_us[TIME_BITS-1:0];
    assign wait_normal_t = {{TPAD{1'b0}}, cfg.wait_normal_us};
    assign wait_sel_t    = item.need_more_blocks ? {{TPAD{1'b0}}, cfg.wait_fast_us}
                                                 : wait_normal_t;
    assign spacing_t     = {{TPAD{1'b0}}, cfg.min_spacing_us};
    assign limit_t       = {{(TIME_BITS-20){1'b0}}, cfg.catch_up_limit_us};
    assign frame_16      = {4'd0, cfg.frame_samples};
    assign count_match   = (queued_reg == item.processed_frames);

    // seeded view of the stored times; unseeded differences are known constants
    assign mark_eff    = seeded_reg ? mark_reg  : now_t - wait_normal_t;
    assign open_eff    = seeded_reg ? open_reg  : now_t;
    assign paced_eff   = seeded_reg ? paced_reg : now_t - spacing_t;
    assign lag         = seeded_reg ? now_t - mark_reg  : wait_normal_t;
    assign since_open  = seeded_reg ? now_t - open_reg  : '0;
    assign since_paced = seeded_reg ? now_t - paced_reg : spacing_t;
    assign budget_sum  = {1'b0, budget_reg} + {1'b0, item.grant_samples};

    // command decode and next state
    always_comb
    begin
        mark_next   = mark_reg;
        open_next   = open_reg;
        paced_next  = paced_reg;
        seeded_next = seeded_reg;
        queued_next = queued_reg;
        budget_next = budget_reg;
        passed      = 1'b0;
        queued      = 1'b0;
        case (item.cmd)
            CMD_UPDATE:
            begin
                seeded_next = 1'b1;
                mark_next   = mark_eff;
                open_next   = open_eff;
                paced_next  = paced_eff;
                if (cfg.pacing_mode)
                begin
                    if (budget_reg >= frame_16 && since_paced >= spacing_t)
                    begin
                        passed = 1'b1;
                        if (item.initialized && count_match)
                        begin
                            queued      = 1'b1;
                            queued_next = queued_reg + 32'd1;
                            budget_next = budget_reg - frame_16;
                            paced_next  = now_t;
                        end
                    end
                end
                else
                begin
                    if (lag >= wait_sel_t && since_open >= spacing_t)
                    begin
                        passed    = 1'b1;
                        open_next = now_t;
                        // skip forward when far behind, else advance one interval
                        if (lag >= limit_t)
                            mark_next = now_t - wait_sel_t;
                        else
                            mark_next = mark_eff + wait_sel_t;
                        if (item.initialized && count_match)
                        begin
                            queued      = 1'b1;
                            queued_next = queued_reg + 32'd1;
                        end
                    end
                end
            end
            CMD_GRANT:
            begin
                // saturate at the cap
                if (budget_sum < {1'b0, cfg.budget_cap})
                    budget_next = budget_sum[15:0];
                else
                    budget_next = cfg.budget_cap;
            end
            CMD_RESTART:
            begin
                queued_next = '0;
            end
            default:
            begin
                queued_next = queued_reg;
            end
        endcase
    end

    assign result.gate_passed  = passed;
    assign result.frame_queued = queued;
    assign result.queued_count = queued_next;
    assign result.budget_level = budget_next;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg <= 1'b0;
            queued_reg <= '0;
            budget_reg <= '0;
        end
        else if (fire)
        begin
            seeded_reg <= seeded_next;
            queued_reg <= queued_next;
            budget_reg <= budget_next;
        end
    end

    // stored times, meaningful once seeded
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            mark_reg  <= mark_next;
            open_reg  <= open_next;
            paced_reg <= paced_next;
        end
    end

    // a queued frame always means the gate opened
    a_queued_passed: assert property (@(posedge clk) disable iff (!rst_n)
        queued |-> passed)
        else $error("frame queued without gate pass");

    // only update checks open the gate
    a_pass_update: assert property (@(posedge clk) disable iff (!rst_n)
        (item.cmd != CMD_UPDATE) |-> !passed)
        else $error("gate passed on non-update command");

    // queuing a frame bumps the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && queued) |=> (queued_reg == $past(queued_reg) + 32'd1))
        else $error("queued count did not advance");

    // state holds between beats
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> ($stable(queued_reg) && $stable(budget_reg) && $stable(seeded_reg)))
        else $error("state changed without a beat");

endmodule

// ===== sv/audio_frame_pacing_gate.sv =====
`timescale 1ns / 1ps

// audio frame pacing gate
// in channel (in_valid, in_stall, in_data) carries one command per beat:
// an update check with a timestamp, a sample grant or a count restart.
// out channel (out_valid, out_stall, out_data) returns exactly one result
// per command: gate pass, frame queued, queued count and budget level.
// the cfg port (cfg_wr_en, cfg_index, cfg_data) writes one register per
// cycle; write it only while no command is in flight.
// an accepted command waits in the input register; when it advances, its
// result is written into the result register. throughput: one command
// per cycle while out_stall is low; the gate state is read and updated
// by one pass of compares and 48-bit subtracts between the two registers.
// when the receiver stalls, the result register holds and the input
// register still takes one more beat before in_stall rises.
// reset clears both registers' valid flags, the queued count, the budget
// and the time-seeded flag, and loads the register defaults; the first
// update after reset seeds the stored times from its timestamp.
module audio_frame_pacing_gate import afpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_item_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_item_t                 out_data,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    cfg_t      cfg_reg, cfg_next;
    logic      in_full_reg, in_full_next;
    in_item_t  in_item_reg;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_item_reg;
    out_item_t core_result;
    logic      accept, advance;

    // pipeline handshake
    assign advance        = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_full_reg && !advance;
    assign accept         = in_valid && !in_stall;
    assign in_full_next   = accept || (in_full_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);
    assign out_valid      = out_valid_reg;
    assign out_data       = out_item_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PACING_MODE:  cfg_next.pacing_mode       = cfg_data[0];
                REG_WAIT_NORMAL:  cfg_next.wait_normal_us    = cfg_data[15:0];
                REG_WAIT_FAST:    cfg_next.wait_fast_us      = cfg_data[15:0];
                REG_MIN_SPACING:  cfg_next.min_spacing_us    = cfg_data[15:0];
                REG_CATCH_UP:     cfg_next.catch_up_limit_us = cfg_data[19:0];
                REG_BUDGET_CAP:   cfg_next.budget_cap        = cfg_data[15:0];
                REG_FRAME_SAMPLE: cfg_next.frame_samples     = cfg_data[11:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pacing_mode       <= RST_PACING_MODE;
            cfg_reg.wait_normal_us    <= RST_WAIT_NORMAL;
            cfg_reg.wait_fast_us      <= RST_WAIT_FAST;
            cfg_reg.min_spacing_us    <= RST_MIN_SPACING;
            cfg_reg.catch_up_limit_us <= RST_CATCH_UP;
            cfg_reg.budget_cap        <= RST_BUDGET_CAP;
            cfg_reg.frame_samples     <= RST_FRAME_SAMPLES;
            in_full_reg               <= 1'b0;
            out_valid_reg             <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_full_reg   <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= in_data;
        if (advance)
            out_item_reg <= core_result;
    end

    afpg_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // a stalled result is never dropped
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result lost");

    // input stage only stalls while the result stage is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_full_reg))
        else $error("input stalled without a blocked result");

    // a beat moved forward lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat missing from result register");

endmodule

// ===== sim/audio_frame_pacing_gate_test.sv =====
`timescale 1ns / 1ps

module audio_frame_pacing_gate_test;
    import afpg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 150;
    localparam int DIRECTED_COUNT = 23;
    // row at which the directed walk switches to the budget gate
    localparam int BUDGET_ROW = 15;

    typedef struct packed {
        in_item_t  beat;
        logic      typed;
        out_item_t want;
    } directed_row_t;

    // directed rows, typed results only where they follow at a glance
    localparam directed_row_t DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
        // first update after reset seeds the stamps, spacing not met yet
        '{'{CMD_UPDATE, 48'd10000, 1'b0, 1'b1, 32'd0, 16'd0}, 1'b1, '{1'b0, 1'b0, 32'd0, 16'd0}},
        '{'{CMD_UPDATE, 48'd11700, 1'b0, 1'b1, 32'd0, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd13000, 1'b0, 1'b1, 32'd0, 16'd0}, 1'b0, '0},
        // fast wait, count differs from processed
        '{'{CMD_UPDATE, 48'd14700, 1'b1, 1'b1, 32'd0, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd16000, 1'b1, 1'b1, 32'd1, 16'd0}, 1'b0, '0},
        // gate opens while the core is not initialized
        '{'{CMD_UPDATE, 48'd17600, 1'b0, 1'b0, 32'd1, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd17601, 1'b1, 1'b1, 32'd1, 16'd0}, 1'b0, '0},
        // long lag, mark skips forward
        '{'{CMD_UPDATE, 48'd200000, 1'b0, 1'b1, 32'd1, 16'd0}, 1'b0, '0},
        // clock stepped back
        '{'{CMD_UPDATE, 48'd5, 1'b0, 1'b1, 32'd2, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, '1, 1'b1, 1'b1, '1, '1}, 1'b0, '0},
        // grant saturates at the cap
        '{'{CMD_GRANT, 48'd0, 1'b0, 1'b1, 32'd0, 16'hFFFF}, 1'b1,
          '{1'b0, 1'b0, 32'd3, 16'd12000}},
        '{'{CMD_GRANT, '1, 1'b1, 1'b0, '1, 16'd0}, 1'b0, '0},
        '{'{CMD_UNUSED, '1, 1'b1, 1'b1, '1, '1}, 1'b0, '0},
        '{'{CMD_RESTART, 48'd0, 1'b0, 1'b1, 32'd0, 16'd0}, 1'b1,
          '{1'b0, 1'b0, 32'd0, 16'd12000}},
        '{'{CMD_UPDATE, 48'd300000, 1'b1, 1'b1, 32'd0, 16'd0}, 1'b0, '0},
        // budget gate from here on
        '{'{CMD_UPDATE, 48'd300000, 1'b0, 1'b1, 32'd1, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd301000, 1'b0, 1'b1, 32'd2, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd301700, 1'b0, 1'b0, 32'd2, 16'd0}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd301700, 1'b0, 1'b1, 32'd2, 16'd0}, 1'b0, '0},
        '{'{CMD_GRANT, 48'd0, 1'b0, 1'b1, 32'd0, 16'd1}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd310000, 1'b0, 1'b1, 32'd0, 16'd0}, 1'b0, '0},
        '{'{CMD_RESTART, '1, 1'b1, 1'b1, '1, '1}, 1'b0, '0},
        '{'{CMD_UPDATE, 48'd0, 1'b0, 1'b1, 32'd0, 16'd0}, 1'b0, '0}
    };

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // predictor state and its copy of the registers
    cfg_t gate_cfg;
    logic [47:0] pace_mark;
    logic [47:0] open_stamp;
    logic [47:0] paced_stamp;
    logic stamps_seeded;
    logic [31:0] frames_queued;
    logic [15:0] sample_credit;

    out_item_t awaited_results[$];
    logic [47:0] stamp_cursor = '0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    audio_frame_pacing_gate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result beat with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_data.gate_passed !== want.gate_passed)
                begin
                    $error("gate_passed: expected %0d, got %0d",
                           want.gate_passed, out_data.gate_passed);
                    mismatch_count++;
                end
                if (out_data.frame_queued !== want.frame_queued)
                begin
                    $error("frame_queued: expected %0d, got %0d",
                           want.frame_queued, out_data.frame_queued);
                    mismatch_count++;
                end
                if (out_data.queued_count !== want.queued_count)
                begin
                    $error("queued_count: expected %0d, got %0d",
                           want.queued_count, out_data.queued_count);
                    mismatch_count++;
                end
                if (out_data.budget_level !== want.budget_level)
                begin
                    $error("budget_level: expected %0d, got %0d",
                           want.budget_level, out_data.budget_level);
                    mismatch_count++;
                end
            end
        end
    end

    // gate decision for one command, updates the predictor state
    function automatic out_item_t gate_predict(input in_item_t c);
        out_item_t r;
        logic [47:0] wait_us;
        logic [47:0] lag;
        logic [16:0] sum;
        r = '0;
        case (c.cmd)
            CMD_UPDATE:
            begin
                if (!stamps_seeded)
                begin
                    pace_mark = c.now_us - 48'(gate_cfg.wait_normal_us);
                    open_stamp = c.now_us;
                    paced_stamp = c.now_us - 48'(gate_cfg.min_spacing_us);
                    stamps_seeded = 1'b1;
                end
                if (gate_cfg.pacing_mode)
                begin
                    lag = c.now_us - paced_stamp;
                    if (sample_credit >= 16'(gate_cfg.frame_samples) &&
                        lag >= 48'(gate_cfg.min_spacing_us))
                    begin
                        r.gate_passed = 1'b1;
                        if (c.initialized && frames_queued == c.processed_frames)
                        begin
                            r.frame_queued = 1'b1;
                            frames_queued = frames_queued + 32'd1;
                            sample_credit = sample_credit - 16'(gate_cfg.frame_samples);
                            paced_stamp = c.now_us;
                        end
                    end
                end
                else
                begin
                    wait_us = c.need_more_blocks ? 48'(gate_cfg.wait_fast_us)
                                                 : 48'(gate_cfg.wait_normal_us);
                    lag = c.now_us - pace_mark;
                    sum = '0;
                    if (lag >= wait_us &&
                        48'(c.now_us - open_stamp) >= 48'(gate_cfg.min_spacing_us))
                    begin
                        r.gate_passed = 1'b1;
                        open_stamp = c.now_us;
                        if (lag >= 48'(gate_cfg.catch_up_limit_us))
                            pace_mark = c.now_us - wait_us;
                        else
                            pace_mark = pace_mark + wait_us;
                        if (c.initialized && frames_queued == c.processed_frames)
                        begin
                            r.frame_queued = 1'b1;
                            frames_queued = frames_queued + 32'd1;
                        end
                    end
                end
            end
            CMD_GRANT:
            begin
                sum = 17'(sample_credit) + 17'(c.grant_samples);
                sample_credit = (sum < 17'(gate_cfg.budget_cap)) ? sum[15:0]
                                                                : gate_cfg.budget_cap;
            end
            CMD_RESTART:
            begin
                frames_queued = '0;
            end
            default:
            begin
            end
        endcase
        r.queued_count = frames_queued;
        r.budget_level = sample_credit;
        return r;
    endfunction

    // present one beat after a random gap, predict once it is taken
    task automatic send_beat(input in_item_t beat, input logic typed,
                             input out_item_t typed_want);
        out_item_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = gate_predict(beat);
        if (typed)
            want = typed_want;
        awaited_results.push_back(want);
        @(negedge clk);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // write all registers while the block is idle
    task automatic apply_settings(input cfg_t s);
        cfg_idx_t idx;
        for (int k = 0; k <= int'(REG_FRAME_SAMPLE); k++)
        begin
            idx = cfg_idx_t'(k);
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            case (idx)
                REG_PACING_MODE:  cfg_data <= CFG_DATA_BITS'(s.pacing_mode);
                REG_WAIT_NORMAL:  cfg_data <= CFG_DATA_BITS'(s.wait_normal_us);
                REG_WAIT_FAST:    cfg_data <= CFG_DATA_BITS'(s.wait_fast_us);
                REG_MIN_SPACING:  cfg_data <= CFG_DATA_BITS'(s.min_spacing_us);
                REG_CATCH_UP:     cfg_data <= CFG_DATA_BITS'(s.catch_up_limit_us);
                REG_BUDGET_CAP:   cfg_data <= CFG_DATA_BITS'(s.budget_cap);
                default:          cfg_data <= CFG_DATA_BITS'(s.frame_samples);
            endcase
            @(negedge clk);
        end
        cfg_wr_en <= 1'b0;
        gate_cfg = s;
    endtask

    function automatic cfg_t default_settings();
        return '{RST_PACING_MODE, RST_WAIT_NORMAL, RST_WAIT_FAST, RST_MIN_SPACING,
                 RST_CATCH_UP, RST_BUDGET_CAP, RST_FRAME_SAMPLES};
    endfunction

    // settings per phase: defaults, extremes, full and low cap, then random
    function automatic cfg_t pick_settings(input int phase);
        cfg_t s;
        s = default_settings();
        case (phase)
            0: s = default_settings();
            1: s = '{1'b0, 16'd1, 16'd1, 16'd0, 20'd1, 16'd0, 12'd1};
            2: s = '{1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF, 16'hFFFF, 12'hFFF};
            3: s = '{1'b1, 16'd3000, 16'd2900, 16'd300, 20'd72000, 16'hFFFF, 12'd144};
            4: s = '{1'b1, 16'd3000, 16'd2900, 16'd300, 20'd72000, 16'd200, 12'd144};
            5: s = '{1'b0, 16'hFFFF, 16'd1, 16'hFFFF, 20'hFFFFF, 16'd0, 12'hFFF};
            default:
            begin
                s.pacing_mode = 1'($urandom_range(1));
                s.wait_normal_us = 16'($urandom_range(1, 8000));
                s.wait_fast_us = 16'($urandom_range(1, 8000));
                s.min_spacing_us = 16'($urandom_range(0, 5000));
                s.catch_up_limit_us = ($urandom_range(1) == 1)
                    ? 20'($urandom_range(1, 100000)) : 20'($urandom_range(1, 20'hFFFFF));
                s.budget_cap = 16'($urandom_range(0, 65535));
                s.frame_samples = 12'($urandom_range(1, 600));
            end
        endcase
        return s;
    endfunction

    // mostly advancing time and matching counts, with some noise
    function automatic in_item_t make_random_beat();
        in_item_t b;
        int pick;
        int span;
        span = int'(gate_cfg.wait_normal_us);
        if (int'(gate_cfg.min_spacing_us) > span)
            span = int'(gate_cfg.min_spacing_us);
        pick = $urandom_range(99);
        if (pick < 68)
            b.cmd = CMD_UPDATE;
        else if (pick < 90)
            b.cmd = CMD_GRANT;
        else if (pick < 96)
            b.cmd = CMD_RESTART;
        else
            b.cmd = CMD_UNUSED;
        pick = $urandom_range(99);
        if (pick < 85)
            stamp_cursor = stamp_cursor + 48'($urandom_range(0, 2 * span));
        else if (pick < 92)
            stamp_cursor = stamp_cursor + 48'($urandom_range(0, 300000));
        else if (pick < 96)
            stamp_cursor = stamp_cursor - 48'($urandom_range(1, 100000));
        else
            stamp_cursor = 48'({$urandom, $urandom});
        b.now_us = (b.cmd == CMD_UPDATE) ? stamp_cursor : 48'({$urandom, $urandom});
        b.need_more_blocks = 1'($urandom_range(1));
        b.initialized = ($urandom_range(19) != 0);
        pick = $urandom_range(99);
        if (pick < 85)
            b.processed_frames = frames_queued;
        else if (pick < 92)
            b.processed_frames = frames_queued + (($urandom_range(1) == 1) ? 32'd1 : '1);
        else
            b.processed_frames = $urandom;
        if ($urandom_range(99) < 70)
            b.grant_samples = 16'($urandom_range(0, 3 * int'(gate_cfg.frame_samples)));
        else
            b.grant_samples = 16'($urandom_range(0, 65535));
        return b;
    endfunction

    initial
    begin
        gate_cfg = default_settings();
        pace_mark = '0;
        open_stamp = '0;
        paced_stamp = '0;
        stamps_seeded = 1'b0;
        frames_queued = '0;
        sample_credit = '0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            if (i == BUDGET_ROW)
            begin
                drain_results();
                apply_settings('{1'b1, RST_WAIT_NORMAL, RST_WAIT_FAST, RST_MIN_SPACING,
                                 RST_CATCH_UP, RST_BUDGET_CAP, RST_FRAME_SAMPLES});
            end
            send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].typed,
                      DIRECTED_ROWS[i].want);
        end

        // random phases under changing settings and idling
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_results();
            apply_settings(pick_settings(phase));
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // sender waits for the pipeline to empty once in a while
                if (k == PHASE_ITEMS / 2 && phase % 2 == 1)
                    drain_results();
                send_beat(make_random_beat(), 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
